### hdl/radio_scan_sequencer_core_assert.svh
// Assertion macros for the radio scan sequencer core.
`ifndef RADIO_SCAN_SEQUENCER_CORE_ASSERT_SVH
`define RADIO_SCAN_SEQUENCER_CORE_ASSERT_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define RSS_ASSERT(name, clock, rst_n, prop, msg) \
	name: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RSS_ASSERT_ALWAYS(name, clock, prop, msg) \
	name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/rss_pkg.sv
// Shared types and constants for the radio scan sequencer.
`default_nettype none
package rss_pkg;

	localparam logic [1:0]  SETTLE_LEN  = 2'd3;
	localparam logic [15:0] HOLDOFF_LEN = 16'd50;
	localparam logic [15:0] NO_CHAN     = 16'hFFFF;

	localparam logic [12:0] TPS_RESET   = 13'd10;
	localparam logic [15:0] TIMED_RESET = 16'd500;

	localparam logic [2:0] CFG_RESUME_KIND    = 3'd0;
	localparam logic [2:0] CFG_TICKS_PER_STEP = 3'd1;
	localparam logic [2:0] CFG_TIMED_RESUME   = 3'd2;
	localparam logic [2:0] CFG_RANGE_LOW      = 3'd3;
	localparam logic [2:0] CFG_RANGE_HIGH     = 3'd4;

	typedef enum logic [1:0] {
		FUNC_TICK      = 2'd0,
		FUNC_FREQ_SCAN = 2'd1,
		FUNC_CHAN_SCAN = 2'd2,
		FUNC_STOP      = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_FREQ = 2'd1,
		MODE_CHAN = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		RESUME_HOLDOFF = 2'd0,
		RESUME_TIMED   = 2'd1,
		RESUME_MANUAL  = 2'd2
	} resume_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_FULL_STEP = 3'd1,
		ACT_SET_FREQ  = 3'd2,
		ACT_LOAD_CHAN = 3'd3,
		ACT_STOPPED   = 3'd4
	} action_t;

	typedef struct packed {
		resume_t     resume_kind;
		logic [12:0] ticks_per_step;
		logic [15:0] timed_resume_ticks;
		logic [31:0] range_low_hz;
		logic [31:0] range_high_hz;
	} cfg_t;

	typedef struct packed {
		func_t       func;
		logic        squelch_open;
		logic [31:0] tuned_freq_hz;
		logic [31:0] tuning_step_hz;
		logic [15:0] next_scannable;
	} req_t;

	typedef struct packed {
		mode_t       mode;
		logic        paused;
		logic [15:0] interval_count;
		logic [1:0]  settle_count;
		logic [15:0] resume_count;
		logic [15:0] current_chan;
	} scan_state_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] new_freq_hz;
		logic [15:0] channel;
		mode_t       scan_kind;
		logic        is_paused;
	} result_t;

endpackage
`default_nettype wire

### hdl/radio_scan_sequencer_core.sv
// Top level of the radio scan sequencer: request register, state, result register.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    func squelch_open tuned_freq_hz tuning_step_hz
//                                           next_scannable
//  out      source     out_valid/out_ready  action new_freq_hz channel scan_kind is_paused
//  cfg      sink       cfg_we               cfg_idx cfg_data
//
// One request per cycle while the result register is empty or being taken.
// The request register feeds one pass of step logic that updates the scan state and
// loads the result register in the same cycle.
// A stalled result holds the result register; one more request can wait behind it.
// Reset clears scan state and loads register defaults; no clearing pass.
`default_nettype none
module radio_scan_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        squelch_open,
	input  logic [31:0] tuned_freq_hz,
	input  logic [31:0] tuning_step_hz,
	input  logic [15:0] next_scannable,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [31:0] new_freq_hz,
	output logic [15:0] channel,
	output logic [1:0]  scan_kind,
	output logic        is_paused,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	import rss_pkg::*;

	cfg_t        cfg_q;
	scan_state_t state_q;
	scan_state_t state_nxt;
	req_t        req_s1;
	logic        valid_s1;
	result_t     res_nxt;
	result_t     res_s2;
	logic        valid_s2;
	logic        take_s2;
	logic        adv_s1;

	assign take_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && take_s2;
	assign in_ready = !valid_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resume_kind        <= RESUME_HOLDOFF;
			cfg_q.ticks_per_step     <= TPS_RESET;
			cfg_q.timed_resume_ticks <= TIMED_RESET;
			cfg_q.range_low_hz       <= 32'd0;
			cfg_q.range_high_hz      <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RESUME_KIND:    cfg_q.resume_kind <= (cfg_data[1:0] == 2'd3) ?
					RESUME_MANUAL : resume_t'(cfg_data[1:0]);
				CFG_TICKS_PER_STEP: cfg_q.ticks_per_step     <= cfg_data[12:0];
				CFG_TIMED_RESUME:   cfg_q.timed_resume_ticks <= cfg_data[15:0];
				CFG_RANGE_LOW:      cfg_q.range_low_hz       <= cfg_data;
				CFG_RANGE_HIGH:     cfg_q.range_high_hz      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.func           <= func_t'(func);
			req_s1.squelch_open   <= squelch_open;
			req_s1.tuned_freq_hz  <= tuned_freq_hz;
			req_s1.tuning_step_hz <= tuning_step_hz;
			req_s1.next_scannable <= next_scannable;
		end
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (take_s2) begin
				valid_s1 <= 1'b0;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	rss_step u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.req (req_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	assign out_valid   = valid_s2;
	assign action      = res_s2.action;
	assign new_freq_hz = res_s2.new_freq_hz;
	assign channel     = res_s2.channel;
	assign scan_kind   = res_s2.scan_kind;
	assign is_paused   = res_s2.is_paused;

`include "radio_scan_sequencer_core_assert.svh"

	`RSS_ASSERT(a_pause_needs_scan, clk, arst_n, state_q.paused |-> state_q.mode != MODE_OFF, "paused while scan is off")
	`RSS_ASSERT(a_stop_ends_scan, clk, arst_n, (valid_s2 && res_s2.action == ACT_STOPPED) |-> res_s2.scan_kind == MODE_OFF, "stopped result with scan still on")
	`RSS_ASSERT(a_freq_only_on_set, clk, arst_n, (valid_s2 && res_s2.action != ACT_SET_FREQ) |-> res_s2.new_freq_hz == 32'd0, "frequency given without set frequency")
	`RSS_ASSERT(a_s1_moves_on, clk, arst_n, (valid_s1 && !valid_s2) |=> valid_s2, "request not moved to empty result register")

endmodule
`default_nettype wire

### hdl/rss_step.sv
// Next-state and result logic for one scan sequencer request.
`default_nettype none
module rss_step (
	input  rss_pkg::scan_state_t cur,
	input  rss_pkg::cfg_t        cfg,
	input  rss_pkg::req_t        req,
	output rss_pkg::scan_state_t nxt,
	output rss_pkg::result_t     res
);
	import rss_pkg::*;

	logic [15:0] limit;
	logic [15:0] interval_inc;
	logic [15:0] resume_dec;
	logic [32:0] freq_sum;
	logic        range_on;
	action_t     action;
	logic [31:0] freq;

	assign limit        = (cfg.ticks_per_step == 13'd0) ? 16'd1 : {3'b000, cfg.ticks_per_step};
	assign interval_inc = cur.interval_count + 16'd1;
	assign resume_dec   = (cur.resume_count != 16'd0) ? cur.resume_count - 16'd1 : 16'd0;
	assign freq_sum     = {1'b0, req.tuned_freq_hz} + {1'b0, req.tuning_step_hz};
	assign range_on     = (cfg.range_low_hz != 32'd0) && (cfg.range_high_hz != 32'd0);

	always_comb begin
		nxt    = cur;
		action = ACT_NONE;
		freq   = 32'd0;
		case (req.func)
			FUNC_TICK: begin
				if (cur.mode != MODE_OFF) begin
					if (cur.paused) begin
						case (cfg.resume_kind)
							RESUME_HOLDOFF: begin
								if (req.squelch_open) begin
									nxt.resume_count = HOLDOFF_LEN;
								end else begin
									nxt.resume_count = resume_dec;
									if (resume_dec == 16'd0) nxt.paused = 1'b0;
								end
							end
							RESUME_TIMED: begin
								nxt.resume_count = resume_dec;
								if (resume_dec == 16'd0) nxt.paused = 1'b0;
							end
							default: ;
						endcase
					end else if (cur.settle_count != 2'd0) begin
						nxt.settle_count = cur.settle_count - 2'd1;
						if (cur.settle_count == 2'd1 && req.squelch_open) begin
							nxt.paused       = 1'b1;
							nxt.resume_count = (cfg.resume_kind == RESUME_HOLDOFF) ?
								HOLDOFF_LEN : cfg.timed_resume_ticks;
						end
					end else if (interval_inc < limit) begin
						nxt.interval_count = interval_inc;
					end else begin
						nxt.interval_count = 16'd0;
						if (cur.mode == MODE_FREQ) begin
							nxt.settle_count = SETTLE_LEN;
							if (range_on) begin
								action = ACT_SET_FREQ;
								freq   = (freq_sum > {1'b0, cfg.range_high_hz}) ?
									cfg.range_low_hz : freq_sum[31:0];
							end else begin
								action = ACT_FULL_STEP;
							end
						end else if (req.next_scannable == NO_CHAN) begin
							nxt.mode         = MODE_OFF;
							nxt.paused       = 1'b0;
							nxt.settle_count = 2'd0;
							action           = ACT_STOPPED;
						end else begin
							nxt.current_chan = req.next_scannable;
							nxt.settle_count = SETTLE_LEN;
							action           = ACT_LOAD_CHAN;
						end
					end
				end
			end
			FUNC_FREQ_SCAN: begin
				nxt.mode           = MODE_FREQ;
				nxt.paused         = 1'b0;
				nxt.interval_count = 16'd0;
				nxt.settle_count   = 2'd0;
			end
			FUNC_CHAN_SCAN: begin
				nxt.mode           = MODE_CHAN;
				nxt.paused         = 1'b0;
				nxt.interval_count = 16'd0;
				nxt.settle_count   = 2'd0;
				nxt.current_chan   = req.next_scannable;
			end
			FUNC_STOP: begin
				nxt.mode           = MODE_OFF;
				nxt.paused         = 1'b0;
				nxt.interval_count = 16'd0;
				nxt.settle_count   = 2'd0;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.action      = action;
		res.new_freq_hz = freq;
		res.channel     = (nxt.mode == MODE_CHAN) ? nxt.current_chan : NO_CHAN;
		res.scan_kind   = nxt.mode;
		res.is_paused   = nxt.paused;
	end

endmodule
`default_nettype wire

### tb/radio_scan_sequencer_core_tb.sv
// Self-checking testbench for radio_scan_sequencer_core: scan state predictor and result checker.
module radio_scan_sequencer_core_tb;
	import rss_pkg::*;

	localparam int STALL_LIMIT = 2000;

	class scan_checker;
		cfg_t        cfg;
		mode_t       mode;
		logic        paused;
		logic [15:0] interval_cnt;
		logic [1:0]  settle_cnt;
		logic [15:0] resume_cnt;
		logic [15:0] cur_chan;
		result_t     pending_results[$];
		int          errors;

		function new();
			cfg.resume_kind = RESUME_HOLDOFF;
			cfg.ticks_per_step = TPS_RESET;
			cfg.timed_resume_ticks = TIMED_RESET;
			cfg.range_low_hz = '0;
			cfg.range_high_hz = '0;
			mode = MODE_OFF;
			paused = 1'b0;
			interval_cnt = '0;
			settle_cnt = '0;
			resume_cnt = '0;
			cur_chan = '0;
			errors = 0;
		endfunction

		function void set_cfg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				CFG_RESUME_KIND: begin
					cfg.resume_kind = (d[1:0] == 2'd3) ? RESUME_MANUAL : resume_t'(d[1:0]);
				end
				CFG_TICKS_PER_STEP: cfg.ticks_per_step = d[12:0];
				CFG_TIMED_RESUME:   cfg.timed_resume_ticks = d[15:0];
				CFG_RANGE_LOW:      cfg.range_low_hz = d;
				CFG_RANGE_HIGH:     cfg.range_high_hz = d;
				default: ;
			endcase
		endfunction

		function void halt();
			mode = MODE_OFF;
			paused = 1'b0;
			interval_cnt = '0;
			settle_cnt = '0;
		endfunction

		function void serve_pause(logic sq);
			if (cfg.resume_kind == RESUME_HOLDOFF && sq) begin
				resume_cnt = HOLDOFF_LEN;
			end else if (cfg.resume_kind == RESUME_HOLDOFF || cfg.resume_kind == RESUME_TIMED) begin
				if (resume_cnt != 0)
					resume_cnt = resume_cnt - 16'd1;
				if (resume_cnt == 0)
					paused = 1'b0;
			end
		endfunction

		function void take_request(req_t r);
			result_t     e;
			logic [15:0] lim;
			logic [32:0] sum;
			e.action = ACT_NONE;
			e.new_freq_hz = '0;
			lim = (cfg.ticks_per_step == 0) ? 16'd1 : {3'd0, cfg.ticks_per_step};
			case (r.func)
				FUNC_TICK: begin
					if (mode == MODE_OFF) begin
					end else if (paused) begin
						serve_pause(r.squelch_open);
					end else if (settle_cnt != 0) begin
						settle_cnt = settle_cnt - 2'd1;
						if (settle_cnt == 0 && r.squelch_open) begin
							paused = 1'b1;
							resume_cnt = (cfg.resume_kind == RESUME_HOLDOFF) ? HOLDOFF_LEN
								: cfg.timed_resume_ticks;
						end
					end else begin
						interval_cnt = interval_cnt + 16'd1;
						if (interval_cnt >= lim) begin
							interval_cnt = '0;
							if (mode == MODE_FREQ) begin
								settle_cnt = SETTLE_LEN;
								if (cfg.range_low_hz != 0 && cfg.range_high_hz != 0) begin
									sum = {1'b0, r.tuned_freq_hz} + {1'b0, r.tuning_step_hz};
									if (sum > {1'b0, cfg.range_high_hz})
										sum = {1'b0, cfg.range_low_hz};
									e.new_freq_hz = sum[31:0];
									e.action = ACT_SET_FREQ;
								end else begin
									e.action = ACT_FULL_STEP;
								end
							end else if (r.next_scannable == NO_CHAN) begin
								halt();
								e.action = ACT_STOPPED;
							end else begin
								cur_chan = r.next_scannable;
								settle_cnt = SETTLE_LEN;
								e.action = ACT_LOAD_CHAN;
							end
						end
					end
				end
				FUNC_STOP: halt();
				default: begin
					mode = (r.func == FUNC_FREQ_SCAN) ? MODE_FREQ : MODE_CHAN;
					paused = 1'b0;
					interval_cnt = '0;
					settle_cnt = '0;
					if (r.func == FUNC_CHAN_SCAN)
						cur_chan = r.next_scannable;
				end
			endcase
			e.channel = (mode == MODE_CHAN) ? cur_chan : NO_CHAN;
			e.scan_kind = mode;
			e.is_paused = paused;
			pending_results.push_back(e);
		endfunction

		function void match_result(result_t a);
			result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending, action %0d", $time, a.action);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (a.action !== e.action) begin
				$display("%0t: action expected %0d actual %0d", $time, e.action, a.action);
				errors++;
			end
			if (a.new_freq_hz !== e.new_freq_hz) begin
				$display("%0t: new_freq_hz expected %0d actual %0d", $time, e.new_freq_hz,
					a.new_freq_hz);
				errors++;
			end
			if (a.channel !== e.channel) begin
				$display("%0t: channel expected %0d actual %0d", $time, e.channel, a.channel);
				errors++;
			end
			if (a.scan_kind !== e.scan_kind) begin
				$display("%0t: scan_kind expected %0d actual %0d", $time, e.scan_kind,
					a.scan_kind);
				errors++;
			end
			if (a.is_paused !== e.is_paused) begin
				$display("%0t: is_paused expected %0d actual %0d", $time, e.is_paused,
					a.is_paused);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic        squelch_open;
	logic [31:0] tuned_freq_hz;
	logic [31:0] tuning_step_hz;
	logic [15:0] next_scannable;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  action;
	logic [31:0] new_freq_hz;
	logic [15:0] channel;
	logic [1:0]  scan_kind;
	logic        is_paused;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;

	scan_checker sb = new();
	req_t        stim_q[$];
	int          burst_left = 0;
	int          sq_left = 0;
	logic        sq_level = 1'b0;
	int          rdy_pat = 0;
	int          rdy_left = 0;

	radio_scan_sequencer_core i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void add(func_t f, logic sq, logic [31:0] t, logic [31:0] s, logic [15:0] n);
		req_t r;
		r.func = f;
		r.squelch_open = sq;
		r.tuned_freq_hz = t;
		r.tuning_step_hz = s;
		r.next_scannable = n;
		stim_q.push_back(r);
	endfunction

	function req_t gen_req();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (sb.mode == MODE_OFF && pick < 60)
			r.func = (pick < 30) ? FUNC_FREQ_SCAN : FUNC_CHAN_SCAN;
		else if (pick < 88)
			r.func = FUNC_TICK;
		else if (pick < 94)
			r.func = FUNC_FREQ_SCAN;
		else if (pick < 97)
			r.func = FUNC_CHAN_SCAN;
		else
			r.func = FUNC_STOP;
		if (sq_left == 0) begin
			sq_level = 1'($urandom_range(0, 1));
			sq_left = $urandom_range(1, 80);
		end
		sq_left--;
		r.squelch_open = sq_level;
		r.tuned_freq_hz = ($urandom_range(0, 3) == 0) ? $urandom()
			: sb.cfg.range_high_hz - $urandom_range(0, 1000);
		r.tuning_step_hz = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000);
		r.next_scannable = ($urandom_range(0, 7) == 0) ? NO_CHAN : 16'($urandom());
		return r;
	endfunction

	task run_items(int n, bit rnd);
		int   i;
		req_t r;
		for (i = 0; i < n; i++) begin
			r = rnd ? gen_req() : stim_q.pop_front();
			in_valid <= 1'b1;
			func <= r.func;
			squelch_open <= r.squelch_open;
			tuned_freq_hz <= r.tuned_freq_hz;
			tuning_step_hz <= r.tuning_step_hz;
			next_scannable <= r.next_scannable;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			@(negedge clk);
			if (burst_left == 0 || i == n - 1) begin
				in_valid <= 1'b0;
				if (i != n - 1)
					repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(0, 20);
			end else begin
				burst_left--;
			end
		end
	endtask

	task drain();
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		sb.set_cfg(idx, d);
		@(negedge clk);
	endtask

	task set_config(logic [1:0] rk, logic [12:0] tps, logic [15:0] tmr, logic [31:0] lo,
		logic [31:0] hi);
		write_reg(CFG_RESUME_KIND, {30'd0, rk});
		write_reg(CFG_TICKS_PER_STEP, {19'd0, tps});
		write_reg(CFG_TIMED_RESUME, {16'd0, tmr});
		write_reg(CFG_RANGE_LOW, lo);
		write_reg(CFG_RANGE_HIGH, hi);
		cfg_we <= 1'b0;
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rdy_left == 0) begin
				rdy_pat = $urandom_range(0, 3);
				rdy_left = $urandom_range(20, 200);
			end
			rdy_left--;
			case (rdy_pat)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((rdy_left % 16) < 4);
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		req_t    rq;
		result_t rs;
		if (arst_n && in_valid && in_ready) begin
			rq.func = func_t'(func);
			rq.squelch_open = squelch_open;
			rq.tuned_freq_hz = tuned_freq_hz;
			rq.tuning_step_hz = tuning_step_hz;
			rq.next_scannable = next_scannable;
			sb.take_request(rq);
		end
		if (arst_n && out_valid && out_ready) begin
			rs.action = action_t'(action);
			rs.new_freq_hz = new_freq_hz;
			rs.channel = channel;
			rs.scan_kind = mode_t'(scan_kind);
			rs.is_paused = is_paused;
			sb.match_result(rs);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main_seq
		int          p;
		logic [1:0]  rk;
		logic [12:0] tps;
		logic [15:0] tmr;
		logic [31:0] lo;
		logic [31:0] hi;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		squelch_open = 1'b0;
		tuned_freq_hz = '0;
		tuning_step_hz = '0;
		next_scannable = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add(FUNC_TICK, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_CHAN);
		add(FUNC_FREQ_SCAN, 1'b0, '0, '0, '0);
		repeat (10) add(FUNC_TICK, 1'b0, 32'd1000, 32'd25, 16'd7);
		add(FUNC_STOP, 1'b1, '0, '0, '0);
		run_items(13, 1'b0);

		drain();
		set_config(RESUME_TIMED, 13'd0, 16'd0, 32'd100, 32'hFFFF_FFFF);
		add(FUNC_FREQ_SCAN, 1'b0, '0, '0, '0);
		add(FUNC_TICK, 1'b0, 32'hFFFF_FFF0, 32'h20, '0);
		add(FUNC_TICK, 1'b0, '0, '0, '0);
		add(FUNC_TICK, 1'b0, '0, '0, '0);
		add(FUNC_TICK, 1'b1, '0, '0, '0);
		add(FUNC_TICK, 1'b1, '0, '0, '0);
		add(FUNC_TICK, 1'b0, '0, '0, '0);
		add(FUNC_CHAN_SCAN, 1'b0, '0, '0, NO_CHAN);
		add(FUNC_TICK, 1'b0, '0, '0, 16'd5);
		repeat (3) add(FUNC_TICK, 1'b0, '0, '0, 16'd9);
		add(FUNC_TICK, 1'b0, '0, '0, NO_CHAN);
		add(FUNC_CHAN_SCAN, 1'b0, '0, '0, 16'd0);
		run_items(14, 1'b0);

		for (p = 0; p < 12; p++) begin
			rk = 2'(p % 4);
			tps = (p == 3) ? 13'h1FFF : (p == 6) ? 13'd0 : (p == 9) ? 13'd6553
				: 13'($urandom_range(1, 5));
			tmr = (p == 5) ? 16'hFFFF : (p == 1) ? 16'd0 : 16'($urandom_range(1, 40));
			case (p % 3)
				0: begin
					if ($urandom_range(0, 1) == 0) begin
						lo = '0;
						hi = $urandom();
					end else begin
						lo = $urandom();
						hi = '0;
					end
				end
				1: begin
					lo = $urandom_range(1, 32'h7FFF_FFFF);
					hi = lo + $urandom_range(0, 100000);
				end
				default: begin
					lo = $urandom() | 32'd1;
					hi = 32'hFFFF_FFFF;
				end
			endcase
			drain();
			set_config(rk, tps, tmr, lo, hi);
			run_items((p == 3 || p == 9) ? 40 : 160, 1'b1);
		end

		drain();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
